### src/itrs_pkg.sv
// Shared types and constants for the integer-to-radix-string converter.
// No dependencies; imported by itrs_divider and integer_to_radix_string.
package itrs_pkg;

    localparam int VALUE_WIDTH = 64;
    localparam int BASE_WIDTH  = 6;
    localparam int CHAR_WIDTH  = 8;

    localparam int IN_TDATA_W  = 72;
    localparam int BASE_LSB    = 64;
    localparam int OUT_TDATA_W = 8;

    localparam int CHUNK_BITS  = 8;
    localparam int DIV_STEPS   = (VALUE_WIDTH + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int PAD_WIDTH   = DIV_STEPS * CHUNK_BITS;
    localparam int STEP_W      = $clog2(DIV_STEPS + 1);

    localparam int BUF_DEPTH   = VALUE_WIDTH;
    localparam int BUF_AW      = $clog2(BUF_DEPTH);
    localparam int CNT_W       = $clog2(BUF_DEPTH + 1);

    localparam logic [BASE_WIDTH-1:0] BASE_MIN = 6'd2;
    localparam logic [BASE_WIDTH-1:0] BASE_MAX = 6'd36;
    localparam logic [BASE_WIDTH-1:0] BASE_DEC = 6'd10;

    localparam logic [CHAR_WIDTH-1:0] CH_NUL     = 8'h00;
    localparam logic [CHAR_WIDTH-1:0] CH_MINUS   = 8'h2d;
    localparam logic [CHAR_WIDTH-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CH_LOWER_A = 8'h61;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INV,
        S_SIGN,
        S_DSTART,
        S_DWAIT,
        S_PRE,
        S_EMIT
    } t_state;

    function automatic logic [CHAR_WIDTH-1:0] digit_char(input logic [BASE_WIDTH-1:0] d);
        logic [CHAR_WIDTH-1:0] ext;
        ext = {{(CHAR_WIDTH-BASE_WIDTH){1'b0}}, d};
        if (d < BASE_DEC) begin
            return CH_ZERO + ext;
        end
        return CH_LOWER_A + ext - {{(CHAR_WIDTH-BASE_WIDTH){1'b0}}, BASE_DEC};
    endfunction

endpackage

### src/itrs_divider.sv
// Iterative divider: VALUE_WIDTH-bit dividend by a 6-bit base, CHUNK_BITS
// quotient bits per cycle. Depends on itrs_pkg.
module itrs_divider (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic [itrs_pkg::VALUE_WIDTH-1:0]     i_dividend,
    input  logic [itrs_pkg::BASE_WIDTH-1:0]      i_base,
    output logic                                 o_done,
    output logic [itrs_pkg::VALUE_WIDTH-1:0]     o_quotient,
    output logic [itrs_pkg::BASE_WIDTH-1:0]      o_remainder
);
    import itrs_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [STEP_W-1:0]     r_step;
    logic [PAD_WIDTH-1:0]  r_quo;
    logic [BASE_WIDTH-1:0] r_rem;

    logic [PAD_WIDTH-1:0]  n_quo;
    logic [BASE_WIDTH-1:0] n_rem;

    always_comb begin
        logic [BASE_WIDTH:0]   t;
        logic [BASE_WIDTH-1:0] rem;
        logic [CHUNK_BITS-1:0] bits;
        logic [CHUNK_BITS-1:0] qbits;
        rem   = r_rem;
        bits  = r_quo[PAD_WIDTH-1 -: CHUNK_BITS];
        qbits = '0;
        for (int k = CHUNK_BITS - 1; k >= 0; k--) begin
            t = {rem, bits[k]};
            if (t >= {1'b0, i_base}) begin
                t        = t - {1'b0, i_base};
                qbits[k] = 1'b1;
            end
            rem = t[BASE_WIDTH-1:0];
        end
        n_rem = rem;
        n_quo = (r_quo << CHUNK_BITS) | {{(PAD_WIDTH-CHUNK_BITS){1'b0}}, qbits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_step <= STEP_W'(DIV_STEPS - 1);
        end else if (r_busy) begin
            r_step <= r_step - 1'b1;
            if (r_step == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= {{(PAD_WIDTH-VALUE_WIDTH){1'b0}}, i_dividend};
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo[VALUE_WIDTH-1:0];
    assign o_remainder = r_rem;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_done) |-> $past(r_busy) && $past(r_step) == '0)
        else $error("divider done without finishing its steps");
    a_rem_below_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done && i_base != '0 |-> r_rem < i_base)
        else $error("divider remainder not below base");
    a_busy_done_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_busy && r_done))
        else $error("divider busy and done together");

endmodule

### src/integer_to_radix_string.sv
// Integer to radix string converter, top level.
// Depends on itrs_pkg and itrs_divider.
//
// Slave channel takes one beat: a value (signed only in base 10) and a base (2 to 36).
// Master channel gives one beat per ASCII character, most significant digit
// first, tlast on the final one. In base 10 a negative value starts with '-'.
// A base outside 2..36 gives a single beat with tuser set and data 0.
// o_s_tready is high only while no conversion is in progress; one value is
// worked on at a time.
// Each digit is one pass of the shared divider, an 8-bit-per-cycle restoring
// divider. A value of D digits is divided D times, then given as D beats at
// one per cycle from the digit memory while the master side does not stall;
// worst case is base 2 with 64 digits.
// Results leave through an output register, so a stall on the master side
// only holds the current beat and pauses the sequencer; nothing is lost.
// Synchronous active-low reset returns to idle with the output empty.
module integer_to_radix_string (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [itrs_pkg::IN_TDATA_W-1:0]    i_s_tdata,   // value[63:0], base[69:64], 0
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [itrs_pkg::OUT_TDATA_W-1:0]   o_m_tdata,   // character[7:0]
    output logic                               o_m_tlast,
    output logic [0:0]                         o_m_tuser    // invalid_base[0]
);
    import itrs_pkg::*;

    t_state                 r_state, n_state;
    logic [VALUE_WIDTH-1:0] r_val;
    logic [BASE_WIDTH-1:0]  r_base;
    logic [CNT_W-1:0]       r_cnt;
    logic [BUF_AW-1:0]      r_idx, n_idx;
    logic [BASE_WIDTH-1:0]  r_mem [BUF_DEPTH];
    logic [BASE_WIDTH-1:0]  r_rd_data;

    logic                   r_out_valid;
    logic [CHAR_WIDTH-1:0]  r_out_char, n_out_char;
    logic                   r_out_last, n_out_last;
    logic                   r_out_inv, n_out_inv;
    logic                   w_load;

    logic [VALUE_WIDTH-1:0] w_in_value;
    logic [BASE_WIDTH-1:0]  w_in_base;
    logic                   w_in_bad;
    logic                   w_in_neg;
    logic                   w_s_fire;
    logic                   w_out_free;

    logic                   w_div_start;
    logic [VALUE_WIDTH-1:0] w_div_dividend;
    logic                   w_div_done;
    logic [VALUE_WIDTH-1:0] w_div_quo;
    logic [BASE_WIDTH-1:0]  w_div_rem;
    logic                   w_more;

    assign w_in_value = i_s_tdata[VALUE_WIDTH-1:0];
    assign w_in_base  = i_s_tdata[BASE_LSB +: BASE_WIDTH];
    assign w_in_bad   = (w_in_base < BASE_MIN) || (w_in_base > BASE_MAX);
    assign w_in_neg   = (w_in_base == BASE_DEC) && w_in_value[VALUE_WIDTH-1];
    assign o_s_tready = (r_state == S_IDLE);
    assign w_s_fire   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;

    assign w_more = (w_div_quo != '0) && (r_cnt != CNT_W'(BUF_DEPTH - 1));

    itrs_divider u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (w_div_dividend),
        .i_base      (r_base),
        .o_done      (w_div_done),
        .o_quotient  (w_div_quo),
        .o_remainder (w_div_rem)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_s_fire) begin
                    if (w_in_bad) begin
                        n_state = S_INV;
                    end else if (w_in_neg) begin
                        n_state = S_SIGN;
                    end else begin
                        n_state = S_DSTART;
                    end
                end
            end
            S_INV: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_SIGN: begin
                if (w_out_free) begin
                    n_state = S_DSTART;
                end
            end
            S_DSTART: n_state = S_DWAIT;
            S_DWAIT: begin
                if (w_div_done && !w_more) begin
                    n_state = S_PRE;
                end
            end
            S_PRE: n_state = S_EMIT;
            S_EMIT: begin
                if (w_out_free && r_idx == '0) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        w_div_start    = 1'b0;
        w_div_dividend = r_val;
        w_load         = 1'b0;
        n_out_char     = CH_NUL;
        n_out_last     = 1'b0;
        n_out_inv      = 1'b0;
        n_idx          = r_idx;
        case (r_state)
            S_INV: begin
                w_load     = w_out_free;
                n_out_last = 1'b1;
                n_out_inv  = 1'b1;
            end
            S_SIGN: begin
                w_load     = w_out_free;
                n_out_char = CH_MINUS;
            end
            S_DSTART: begin
                w_div_start = 1'b1;
            end
            S_DWAIT: begin
                w_div_start    = w_div_done && w_more;
                w_div_dividend = w_div_quo;
            end
            S_PRE: begin
                n_idx = BUF_AW'(r_cnt - 1'b1);
            end
            S_EMIT: begin
                w_load     = w_out_free;
                n_out_char = digit_char(r_rd_data);
                n_out_last = (r_idx == '0);
                if (w_out_free && r_idx != '0) begin
                    n_idx = r_idx - 1'b1;
                end
            end
            default: begin
                w_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (w_s_fire) begin
            r_cnt <= '0;
        end else if (r_state == S_DWAIT && w_div_done) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_fire) begin
            r_base <= w_in_base;
            r_val  <= w_in_neg ? (~w_in_value + 1'b1) : w_in_value;
        end else if (r_state == S_DWAIT && w_div_done) begin
            r_val <= w_div_quo;
        end
        r_idx <= n_idx;
        if (w_load) begin
            r_out_char <= n_out_char;
            r_out_last <= n_out_last;
            r_out_inv  <= n_out_inv;
        end
    end

    // digit memory: one write per finished division, one registered read
    always_ff @(posedge i_clk) begin
        if (r_state == S_DWAIT && w_div_done) begin
            r_mem[r_cnt[BUF_AW-1:0]] <= w_div_rem;
        end
        r_rd_data <= r_mem[n_idx];
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_m_tdata    = r_out_char;
    assign o_m_tlast    = r_out_last;
    assign o_m_tuser[0] = r_out_inv;

    a_start_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> (r_state == S_DSTART || r_state == S_DWAIT))
        else $error("divider started outside the divide phase");
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT |-> {1'b0, r_idx} < r_cnt)
        else $error("read index beyond stored digits");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(BUF_DEPTH))
        else $error("digit count overflow");
    a_inv_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tdata == CH_NUL && o_m_tlast)
        else $error("invalid-base beat malformed");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_fire |=> r_state != S_IDLE)
        else $error("accepted beat did not start a conversion");

endmodule
